@@ rtl/i2cseq_pkg.sv @@
`default_nettype none
package i2cseq_pkg;

  localparam int AddrW = 11;
  localparam int LenW  = 12;
  localparam int ByteW = 8;

  localparam logic [7:0] CtrlBase       = 8'hA0;
  localparam logic [7:0] PollTimeoutRst = 8'd20;
  localparam int         MaxResults     = 3;

  typedef enum logic [2:0] {
    FN_READ  = 3'd0,
    FN_WRITE = 3'd1,
    FN_DATA  = 3'd2,
    FN_RESP  = 3'd3,
    FN_TICK  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_NACK  = 3'd4,
    KIND_NEED  = 3'd5,
    KIND_RDATA = 3'd6,
    KIND_DONE  = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R_START, PH_R_CTRL, PH_R_ADDR, PH_R_RESTART, PH_R_CTRL2,
    PH_R_DATA, PH_W_START, PH_W_CTRL, PH_W_ADDR, PH_W_NEED, PH_W_DATA,
    PH_P_START, PH_P_CTRL, PH_P_WAIT
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] byte_value;
    logic             status;
    logic             last;
  } res_t;

  // Up to three results produced by one input beat, in order from res[0].
  typedef struct packed {
    logic [1:0]            n;
    res_t [MaxResults-1:0] res;
  } push_t;

  function automatic res_t mk_res(kind_e k, logic [ByteW-1:0] v, logic st);
    res_t r;
    r.kind       = k;
    r.byte_value = v;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  // Control byte: device code, the three block bits of the address, read bit.
  function automatic logic [7:0] ctrl_byte(logic [AddrW-1:0] a, logic rd);
    return CtrlBase | {4'b0000, a[10:8], 1'b0} | {7'b0000000, rd};
  endfunction

endpackage
`default_nettype wire

@@ rtl/i2c_eeprom_transaction_sequencer_top.sv @@
`default_nettype none
// Sequencer for a 2 KiB I2C EEPROM with 16-byte pages. The host sends read
// and write requests, write data bytes, bus responses and millisecond ticks
// on the slave stream; the block answers with bus commands, data requests,
// read data and a final done beat on the master stream. Each input beat is
// handled in the cycle it is accepted and its results (zero to three) are
// queued. The result queue sends one beat per cycle while m_axis_tready is
// high and takes a new input beat whenever it holds at most one result, so
// the block accepts one beat per cycle as long as the output is not stalled
// and each beat yields at most one result. The acknowledge polling timeout
// is set through the configuration write port and resets to 20 ticks.
module i2c_eeprom_transaction_sequencer_top
  import i2cseq_pkg::*;
#(
  parameter int MEM_BYTES  = 2048,
  parameter int PAGE_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // start_address[10:0], byte_count[22:11], write_data[30:23], bus_ok[31],
  // bus_data[39:32]
  input  wire logic [39:0] s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // byte_value[7:0], status[8], zero[15:9]
  output logic [15:0]      m_axis_tdata,
  // kind[2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  i2cseq_core #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .func_i     (s_axis_tuser),
    .addr_i     (s_axis_tdata[10:0]),
    .len_i      (s_axis_tdata[22:11]),
    .wdata_i    (s_axis_tdata[30:23]),
    .ok_i       (s_axis_tdata[31]),
    .bdata_i    (s_axis_tdata[39:32]),
    .push_o     (push)
  );

  i2cseq_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = {7'b0000000, head.status, head.byte_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

@@ rtl/i2cseq_core.sv @@
`default_nettype none
module i2cseq_core
  import i2cseq_pkg::*;
#(
  parameter int MEM_BYTES  = 2048,
  parameter int PAGE_BYTES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_wdata_i,
  input  wire logic             accept_i,
  input  wire logic [2:0]       func_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [LenW-1:0]  len_i,
  input  wire logic [ByteW-1:0] wdata_i,
  input  wire logic             ok_i,
  input  wire logic [ByteW-1:0] bdata_i,
  output push_t                 push_o
);

  localparam int ChunkW     = $clog2(PAGE_BYTES + 1);
  localparam int RecipShift = 17;
  localparam int Recip      = ((1 << RecipShift) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int RecipW     = $clog2(Recip + 1);
  localparam int ProdW      = AddrW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;

  phase_e            phase_q, phase_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic [7:0]        poll_q, poll_d;
  logic [7:0]        timeout_q;

  // Page split: offset inside the page by reciprocal multiply, exact for
  // every 11-bit address.
  logic [AddrW-1:0]  pg_addr;
  logic [LenW-1:0]   pg_rem;
  logic [ProdW-1:0]  pg_prod;
  logic [QuotW-1:0]  pg_quot;
  logic [AddrW-1:0]  pg_base;
  logic [AddrW-1:0]  pg_off_full;
  logic [ChunkW-1:0] pg_space;
  logic [ChunkW-1:0] pg_chunk;

  assign pg_addr     = (phase_q == PH_IDLE) ? addr_i : addr_q;
  assign pg_rem      = (phase_q == PH_IDLE) ? len_i : rem_q;
  assign pg_prod     = ProdW'(pg_addr) * ProdW'(Recip);
  assign pg_quot     = pg_prod[ProdW-1:RecipShift];
  assign pg_base     = AddrW'(pg_quot) * AddrW'(PAGE_BYTES);
  assign pg_off_full = pg_addr - pg_base;
  assign pg_space    = ChunkW'(PAGE_BYTES) - pg_off_full[ChunkW-1:0];
  assign pg_chunk    = (pg_rem < LenW'(pg_space)) ? pg_rem[ChunkW-1:0] : pg_space;

  logic [LenW:0]    room;
  logic             range_bad;
  logic [AddrW-1:0] addr_inc;
  logic [AddrW-1:0] addr_prev;
  logic [LenW-1:0]  rem_dec;
  logic [ChunkW-1:0] chunk_dec;
  logic [7:0]       poll_inc;

  assign room      = (LenW+1)'(MEM_BYTES) - (LenW+1)'(addr_i);
  assign range_bad = (len_i == '0) || ((LenW+1)'(addr_i) >= (LenW+1)'(MEM_BYTES)) ||
                     ({1'b0, len_i} > room);
  assign addr_inc  = addr_q + AddrW'(1);
  assign addr_prev = addr_q - AddrW'(1);
  assign rem_dec   = (rem_q != '0) ? rem_q - LenW'(1) : rem_q;
  assign chunk_dec = (chunk_q != '0) ? chunk_q - ChunkW'(1) : chunk_q;
  assign poll_inc  = (poll_q == 8'hFF) ? poll_q : poll_q + 8'd1;

  always_comb begin
    logic [1:0]            n;
    res_t [MaxResults-1:0] res;
    n       = 2'd0;
    res     = '0;
    phase_d = phase_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    poll_d  = poll_q;
    if (accept_i) begin
      case (func_i)
        FN_READ, FN_WRITE: begin
          if (phase_q == PH_IDLE) begin
            if (range_bad) begin
              res[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 2'd1;
            end else begin
              addr_d  = addr_i;
              rem_d   = len_i;
              chunk_d = '0;
              poll_d  = '0;
              res[n] = mk_res(KIND_START, 8'h00, 1'b0); n = n + 2'd1;
              if (func_i == FN_WRITE) begin
                chunk_d = pg_chunk;
                phase_d = PH_W_START;
              end else begin
                phase_d = PH_R_START;
              end
            end
          end
        end
        FN_DATA: begin
          if (phase_q == PH_W_NEED) begin
            res[n] = mk_res(KIND_WRITE, wdata_i, 1'b0); n = n + 2'd1;
            phase_d = PH_W_DATA;
          end
        end
        FN_RESP: begin
          case (phase_q)
            PH_R_START, PH_W_START: begin
              if (!ok_i) begin
                res[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 2'd1;
                phase_d = PH_IDLE;
              end else begin
                res[n] = mk_res(KIND_WRITE, ctrl_byte(addr_q, 1'b0), 1'b0); n = n + 2'd1;
                phase_d = (phase_q == PH_R_START) ? PH_R_CTRL : PH_W_CTRL;
              end
            end
            PH_R_CTRL, PH_R_ADDR, PH_R_RESTART, PH_R_CTRL2, PH_W_CTRL, PH_W_ADDR,
            PH_W_DATA: begin
              if (!ok_i) begin
                res[n] = mk_res(KIND_STOP, 8'h00, 1'b0); n = n + 2'd1;
                res[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 2'd1;
                phase_d = PH_IDLE;
              end else begin
                case (phase_q)
                  PH_R_CTRL, PH_W_CTRL: begin
                    res[n] = mk_res(KIND_WRITE, addr_q[7:0], 1'b0); n = n + 2'd1;
                    phase_d = (phase_q == PH_R_CTRL) ? PH_R_ADDR : PH_W_ADDR;
                  end
                  PH_R_ADDR: begin
                    res[n] = mk_res(KIND_START, 8'h00, 1'b0); n = n + 2'd1;
                    phase_d = PH_R_RESTART;
                  end
                  PH_R_RESTART: begin
                    res[n] = mk_res(KIND_WRITE, ctrl_byte(addr_q, 1'b1), 1'b0); n = n + 2'd1;
                    phase_d = PH_R_CTRL2;
                  end
                  PH_R_CTRL2: begin
                    res[n] = mk_res((rem_q > LenW'(1)) ? KIND_ACK : KIND_NACK, 8'h00, 1'b0);
                    n = n + 2'd1;
                    phase_d = PH_R_DATA;
                  end
                  PH_W_ADDR: begin
                    res[n] = mk_res(KIND_NEED, 8'h00, 1'b0); n = n + 2'd1;
                    phase_d = PH_W_NEED;
                  end
                  PH_W_DATA: begin
                    addr_d  = addr_inc;
                    rem_d   = rem_dec;
                    chunk_d = chunk_dec;
                    if ((chunk_dec != '0) && (rem_dec != '0)) begin
                      res[n] = mk_res(KIND_NEED, 8'h00, 1'b0); n = n + 2'd1;
                      phase_d = PH_W_NEED;
                    end else begin
                      // Page done: close it; poll, or fail if timeout is 0.
                      chunk_d = '0;
                      poll_d  = '0;
                      res[n] = mk_res(KIND_STOP, 8'h00, 1'b0); n = n + 2'd1;
                      if (timeout_q == '0) begin
                        res[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 2'd1;
                        phase_d = PH_IDLE;
                      end else begin
                        res[n] = mk_res(KIND_START, 8'h00, 1'b0); n = n + 2'd1;
                        phase_d = PH_P_START;
                      end
                    end
                  end
                  default: ;
                endcase
              end
            end
            PH_R_DATA: begin
              // The data phase takes the byte whatever the acknowledge says.
              res[n] = mk_res(KIND_RDATA, bdata_i, 1'b0); n = n + 2'd1;
              addr_d = addr_inc;
              rem_d  = rem_dec;
              if (rem_dec != '0) begin
                res[n] = mk_res((rem_dec > LenW'(1)) ? KIND_ACK : KIND_NACK, 8'h00, 1'b0);
                n = n + 2'd1;
              end else begin
                res[n] = mk_res(KIND_STOP, 8'h00, 1'b0); n = n + 2'd1;
                res[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 2'd1;
                phase_d = PH_IDLE;
              end
            end
            PH_P_START: begin
              if (!ok_i) begin
                phase_d = PH_P_WAIT;
              end else begin
                res[n] = mk_res(KIND_WRITE, ctrl_byte(addr_prev, 1'b0), 1'b0); n = n + 2'd1;
                phase_d = PH_P_CTRL;
              end
            end
            PH_P_CTRL: begin
              res[n] = mk_res(KIND_STOP, 8'h00, 1'b0); n = n + 2'd1;
              if (!ok_i) begin
                phase_d = PH_P_WAIT;
              end else if (rem_q != '0) begin
                chunk_d = pg_chunk;
                res[n] = mk_res(KIND_START, 8'h00, 1'b0); n = n + 2'd1;
                phase_d = PH_W_START;
              end else begin
                res[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 2'd1;
                phase_d = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        FN_TICK: begin
          if ((phase_q == PH_P_START) || (phase_q == PH_P_CTRL)) begin
            poll_d = poll_inc;
          end else if (phase_q == PH_P_WAIT) begin
            poll_d = poll_inc;
            if (poll_inc >= timeout_q) begin
              res[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 2'd1;
              phase_d = PH_IDLE;
            end else begin
              res[n] = mk_res(KIND_START, 8'h00, 1'b0); n = n + 2'd1;
              phase_d = PH_P_START;
            end
          end
        end
        default: ;
      endcase
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    push_o.n   = n;
    push_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      addr_q    <= '0;
      rem_q     <= '0;
      chunk_q   <= '0;
      poll_q    <= '0;
      timeout_q <= PollTimeoutRst;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      chunk_q <= chunk_d;
      poll_q  <= poll_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  a_need_has_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_W_NEED) |-> (chunk_q != '0) && (rem_q != '0))
    else $error("data requested with an empty page chunk");

  a_read_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_R_DATA) |-> (rem_q != '0))
    else $error("read data phase with no bytes left");

  a_tick_outside_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (func_i == FN_TICK) && (phase_q != PH_P_START) &&
    (phase_q != PH_P_CTRL) && (phase_q != PH_P_WAIT) |-> (push_o.n == 2'd0) &&
    (poll_d == poll_q) && (phase_d == phase_q))
    else $error("tick outside polling changed the sequencer");

endmodule
`default_nettype wire

@@ rtl/i2cseq_outq.sv @@
`default_nettype none
module i2cseq_outq
  import i2cseq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output res_t       head_o
);

  localparam int Depth = MaxResults + 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int IdxW  = $clog2(Depth);

  res_t [Depth-1:0] slots_q, slots_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[0];
  assign pop     = valid_o && ready_i;
  // Room for a full burst of results, so one beat can enter every cycle
  // while the previous beat's result drains.
  assign room_o  = (cnt_q <= CntW'(1));

  always_comb begin
    logic [CntW-1:0] base;
    slots_d = slots_q;
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        slots_d[i] = slots_q[i + 1];
      end
    end
    base = cnt_q - CntW'(pop);
    for (int k = 0; k < MaxResults; k++) begin
      if (2'(k) < push_i.n) begin
        slots_d[IdxW'(base + CntW'(k))] = push_i.res[k];
      end
    end
    cnt_d = base + CntW'(push_i.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("results pushed into a full result queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(head_o))
    else $error("waiting result beat changed before it was taken");

endmodule
`default_nettype wire

@@ tb/tb_i2c_eeprom_transaction_sequencer_top.sv @@
`timescale 1ns / 100ps
module tb_i2c_eeprom_transaction_sequencer_top;
  import i2cseq_pkg::*;

  localparam int MemBytes    = 2048;
  localparam int PageBytes   = 16;
  localparam int RandomBeats = 430;
  localparam int CycleLimit  = 1_000_000;
  localparam int MaxShown    = 10;

  // Predicts the bus commands and host results of the sequencer and holds
  // them until the block sends them.
  class eeprom_cmd_scoreboard;
    res_t       expected_cmds[$];
    res_t       step_cmds[$];
    logic [7:0] timeout_ticks;
    phase_e     phase;
    logic [10:0] cur_addr;
    logic [11:0] remaining;
    logic [4:0]  chunk_left;
    logic [7:0]  elapsed;
    int          failures;

    function new();
      timeout_ticks = PollTimeoutRst;
      phase         = PH_IDLE;
      cur_addr      = '0;
      remaining     = '0;
      chunk_left    = '0;
      elapsed       = '0;
      failures      = 0;
    endfunction

    function void push_cmd(kind_e k, logic [7:0] v, logic st);
      res_t r;
      r.kind       = k;
      r.byte_value = v;
      r.status     = st;
      r.last       = 1'b0;
      step_cmds.push_back(r);
    endfunction

    function void finish_txn(logic err);
      push_cmd(KIND_DONE, 8'd0, err);
      phase = PH_IDLE;
    endfunction

    function void stop_then_fail();
      push_cmd(KIND_STOP, 8'd0, 1'b0);
      finish_txn(1'b1);
    endfunction

    // Device select: 1010, then address bits 10..8, then the read bit.
    function logic [7:0] dev_select(logic [10:0] a, logic rd);
      return 8'hA0 + (8'(a[10:8]) << 1) + 8'(rd);
    endfunction

    function void open_page();
      int space;
      space      = PageBytes - (int'(cur_addr) % PageBytes);
      chunk_left = (int'(remaining) < space) ? 5'(remaining) : 5'(space);
      push_cmd(KIND_START, 8'd0, 1'b0);
      phase = PH_W_START;
    endfunction

    function void issue_read();
      push_cmd((remaining > 12'd1) ? KIND_ACK : KIND_NACK, 8'd0, 1'b0);
      phase = PH_R_DATA;
    endfunction

    function void on_bus_response(logic ok, logic [7:0] data);
      logic [10:0] page_addr;
      page_addr = cur_addr - 11'd1;
      case (phase)
        PH_R_START: begin
          if (!ok) finish_txn(1'b1);
          else begin
            push_cmd(KIND_WRITE, dev_select(cur_addr, 1'b0), 1'b0);
            phase = PH_R_CTRL;
          end
        end
        PH_R_CTRL: begin
          if (!ok) stop_then_fail();
          else begin
            push_cmd(KIND_WRITE, cur_addr[7:0], 1'b0);
            phase = PH_R_ADDR;
          end
        end
        PH_R_ADDR: begin
          if (!ok) stop_then_fail();
          else begin
            push_cmd(KIND_START, 8'd0, 1'b0);
            phase = PH_R_RESTART;
          end
        end
        PH_R_RESTART: begin
          if (!ok) stop_then_fail();
          else begin
            push_cmd(KIND_WRITE, dev_select(cur_addr, 1'b1), 1'b0);
            phase = PH_R_CTRL2;
          end
        end
        PH_R_CTRL2: begin
          if (!ok) stop_then_fail();
          else issue_read();
        end
        PH_R_DATA: begin
          // The acknowledge flag means nothing on a read; only the data counts.
          push_cmd(KIND_RDATA, data, 1'b0);
          cur_addr = cur_addr + 11'd1;
          if (remaining > 0) remaining = remaining - 12'd1;
          if (remaining > 0) issue_read();
          else begin
            push_cmd(KIND_STOP, 8'd0, 1'b0);
            finish_txn(1'b0);
          end
        end
        PH_W_START: begin
          if (!ok) finish_txn(1'b1);
          else begin
            push_cmd(KIND_WRITE, dev_select(cur_addr, 1'b0), 1'b0);
            phase = PH_W_CTRL;
          end
        end
        PH_W_CTRL: begin
          if (!ok) stop_then_fail();
          else begin
            push_cmd(KIND_WRITE, cur_addr[7:0], 1'b0);
            phase = PH_W_ADDR;
          end
        end
        PH_W_ADDR: begin
          if (!ok) stop_then_fail();
          else begin
            push_cmd(KIND_NEED, 8'd0, 1'b0);
            phase = PH_W_NEED;
          end
        end
        PH_W_DATA: begin
          if (!ok) stop_then_fail();
          else begin
            cur_addr = cur_addr + 11'd1;
            if (remaining > 0) remaining = remaining - 12'd1;
            if (chunk_left > 0) chunk_left = chunk_left - 5'd1;
            if (chunk_left > 0 && remaining > 0) begin
              push_cmd(KIND_NEED, 8'd0, 1'b0);
              phase = PH_W_NEED;
            end else begin
              chunk_left = '0;
              push_cmd(KIND_STOP, 8'd0, 1'b0);
              elapsed = '0;
              if (timeout_ticks == 8'd0) finish_txn(1'b1);
              else begin
                push_cmd(KIND_START, 8'd0, 1'b0);
                phase = PH_P_START;
              end
            end
          end
        end
        PH_P_START: begin
          if (!ok) phase = PH_P_WAIT;
          else begin
            push_cmd(KIND_WRITE, dev_select(page_addr, 1'b0), 1'b0);
            phase = PH_P_CTRL;
          end
        end
        PH_P_CTRL: begin
          push_cmd(KIND_STOP, 8'd0, 1'b0);
          if (!ok) phase = PH_P_WAIT;
          else if (remaining > 0) open_page();
          else finish_txn(1'b0);
        end
        default: ;
      endcase
    endfunction

    // Returns 1 when the beat is acted on rather than dropped, and also for a response while polling waits for a tick.
    function bit predict_beat(logic [2:0] func, logic [10:0] addr, logic [11:0] len,
                              logic [7:0] wdata, logic ok, logic [7:0] bdata);
      bit acts;
      acts = 1'b0;
      step_cmds.delete();
      case (func)
        FN_READ, FN_WRITE: begin
          if (phase == PH_IDLE) begin
            acts = 1'b1;
            if (len == 0 || int'(addr) >= MemBytes || int'(len) > MemBytes - int'(addr)) begin
              finish_txn(1'b1);
            end else begin
              cur_addr   = addr;
              remaining  = len;
              chunk_left = '0;
              elapsed    = '0;
              if (func == FN_WRITE) open_page();
              else begin
                push_cmd(KIND_START, 8'd0, 1'b0);
                phase = PH_R_START;
              end
            end
          end
        end
        FN_DATA: begin
          if (phase == PH_W_NEED) begin
            acts = 1'b1;
            push_cmd(KIND_WRITE, wdata, 1'b0);
            phase = PH_W_DATA;
          end
        end
        FN_RESP: begin
          acts = (phase != PH_IDLE && phase != PH_W_NEED);
          on_bus_response(ok, bdata);
        end
        FN_TICK: begin
          if (phase == PH_P_START || phase == PH_P_CTRL || phase == PH_P_WAIT) begin
            acts = 1'b1;
            if (elapsed != 8'hFF) elapsed = elapsed + 8'd1;
            if (phase == PH_P_WAIT) begin
              if (elapsed >= timeout_ticks) finish_txn(1'b1);
              else begin
                push_cmd(KIND_START, 8'd0, 1'b0);
                phase = PH_P_START;
              end
            end
          end
        end
        default: ;
      endcase
      if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
      return acts;
    endfunction

    function void check_cmd(kind_e k, logic [7:0] v, logic st, logic lst);
      res_t want;
      if (expected_cmds.size() == 0) begin
        failures++;
        if (failures <= MaxShown)
          $display("%0t: unexpected beat kind=%0d value=%02h status=%b last=%b",
                   $realtime, k, v, st, lst);
        return;
      end
      want = expected_cmds.pop_front();
      if (want.kind !== k || want.byte_value !== v || want.status !== st ||
          want.last !== lst) begin
        failures++;
        if (failures <= MaxShown)
          $display("%0t: mismatch expected kind=%0d value=%02h status=%b last=%b, got kind=%0d value=%02h status=%b last=%b",
                   $realtime, want.kind, want.byte_value, want.status, want.last,
                   k, v, st, lst);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [7:0]  cfg_wdata     = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic [39:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  eeprom_cmd_scoreboard sb = new();
  bit valid_up      = 1'b0;
  bit stall_enable  = 1'b1;
  int counted_beats = 0;
  int stall_left    = 0;
  int cycle_count   = 0;

  i2c_eeprom_transaction_sequencer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check every accepted beat and, while stalls are enabled, stall in random bursts.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_cmd(kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tlast);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (stall_enable && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic lower_valid();
    if (valid_up) begin
      s_axis_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // tvalid stays high from one beat to the next unless a gap is inserted.
  task automatic send_beat(logic [2:0] f, logic [10:0] a, logic [11:0] n, logic [7:0] wd,
                           logic ok, logic [7:0] bd);
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      lower_valid();
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {bd, ok, wd, n, a};
    valid_up = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.predict_beat(f, a, n, wd, ok, bd)) counted_beats++;
  endtask

  task automatic send_any(logic [2:0] f, logic ok);
    send_beat(f, 11'($urandom), 12'($urandom), 8'($urandom), ok, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [7:0] v);
    lower_valid();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.timeout_ticks = v;
  endtask

  // One request followed by whatever the block asks for, until it is idle.
  task automatic run_transaction(int poll_ok_pct);
    logic [10:0] a;
    logic [11:0] n;
    int          room;
    case ($urandom_range(0, 3))
      0: a = 11'($urandom);
      1: a = 11'(MemBytes - $urandom_range(1, 40));
      2: a = {7'($urandom), 4'hF - 4'($urandom_range(0, 2))};
      default: a = {7'($urandom), 4'h0};
    endcase
    room = MemBytes - int'(a);
    case ($urandom_range(0, 19))
      0: n = 12'd0;
      1: n = 12'(room + $urandom_range(1, 4095 - room));
      2: n = 12'((room <= 48) ? room : $urandom_range(1, 48));
      3: n = 12'($urandom_range(40, 80));
      default: n = 12'($urandom_range(1, 36));
    endcase
    if (n != 0 && int'(n) > room && $urandom_range(0, 3) != 0) n = 12'(room);
    send_beat($urandom_range(0, 1) ? FN_WRITE : FN_READ, a, n, 8'($urandom),
              1'($urandom), 8'($urandom));
    while (sb.phase != PH_IDLE) begin
      if ($urandom_range(0, 19) == 0) send_any(3'($urandom_range(0, 7)), 1'($urandom));
      else begin
        case (sb.phase)
          PH_W_NEED: send_any(FN_DATA, 1'($urandom));
          PH_P_WAIT: send_any(FN_TICK, 1'($urandom));
          PH_R_DATA: send_any(FN_RESP, 1'($urandom));
          PH_P_START, PH_P_CTRL: begin
            if ($urandom_range(0, 6) == 0) send_any(FN_TICK, 1'($urandom));
            else send_any(FN_RESP, $urandom_range(0, 99) < poll_ok_pct);
          end
          default: send_any(FN_RESP, $urandom_range(0, 49) != 0);
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] settings [5];
    settings = '{8'd0, 8'd255, 8'd1, 8'd7, 8'd3};
    settings[3] = 8'($urandom_range(2, 30));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Range errors: zero length, overrun past the last byte, largest length.
    send_beat(FN_READ, 11'd5, 12'd0, 8'd0, 1'b0, 8'd0);
    send_beat(FN_WRITE, 11'h7FF, 12'd2, 8'd0, 1'b0, 8'd0);
    send_beat(FN_READ, 11'd0, 12'hFFF, 8'd0, 1'b0, 8'd0);
    // Whole memory write whose first start fails: done error without a stop.
    send_beat(FN_WRITE, 11'd0, 12'd2048, 8'd0, 1'b0, 8'd0);
    send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b0, 8'd0);
    // Beats that an idle block drops.
    send_beat(FN_TICK, 11'h7FF, 12'hFFF, 8'hFF, 1'b1, 8'hFF);
    send_beat(3'd7, 11'h7FF, 12'hFFF, 8'hFF, 1'b1, 8'hFF);
    // Read of the last byte of memory.
    send_beat(FN_READ, 11'h7FF, 12'd1, 8'd0, 1'b0, 8'd0);
    repeat (5) send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b1, 8'd0);
    send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b0, 8'hFF);
    // Write of the last byte with one failed poll before the acknowledge.
    send_beat(FN_WRITE, 11'h7FF, 12'd1, 8'd0, 1'b0, 8'd0);
    repeat (3) send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b1, 8'd0);
    send_beat(FN_DATA, 11'd0, 12'd0, 8'hFF, 1'b0, 8'd0);
    send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b1, 8'd0);
    send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b0, 8'd0);
    send_beat(FN_TICK, 11'd0, 12'd0, 8'd0, 1'b0, 8'd0);
    repeat (2) send_beat(FN_RESP, 11'd0, 12'd0, 8'd0, 1'b1, 8'd0);

    counted_beats = 0;
    for (int s = 0; s < 5; s++) begin
      write_timeout(settings[s]);
      stall_enable = (s < 4);
      while (counted_beats < RandomBeats * (s + 1) / 5) begin
        if ($urandom_range(0, 7) == 0) send_any(3'($urandom_range(2, 7)), 1'($urandom));
        else run_transaction((settings[s] <= 8'd30 && $urandom_range(0, 9) == 0) ? 10 : 70);
      end
    end

    lower_valid();
    wait_drained();
    if (sb.failures == 0 && sb.expected_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
